FILE: hw/rtl/ray_box_slab_intersect_top_assert.svh
// ---------------------------------------------------------------------------
// Ray/box slab intersect assertion macros
// Shared concurrent assertion forms for the ray/box intersect block.
// ---------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH
`define RAY_BOX_SLAB_INTERSECT_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RBSI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RBSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rbsi_pkg.sv
// ---------------------------------------------------------------------------
// Ray/box slab intersect package
// Types and fixed constants shared by the lanes, the merge stage and the top.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rbsi_pkg;

   localparam int unsigned DATA_W   = 32;
   localparam int unsigned DIFF_W   = DATA_W + 1;
   localparam int unsigned QUO_W    = DATA_W;
   localparam int unsigned NUM_AXES = 3;

   // Divider: magnitude stage, first remainder stage, one stage per
   // quotient bit, sign and saturation stage.
   localparam int unsigned DIV_LAT   = QUO_W + 3;
   localparam int unsigned LANE_LAT  = DIV_LAT + 2;
   localparam int unsigned MERGE_LAT = 3;
   localparam int unsigned TOTAL_LAT = LANE_LAT + MERGE_LAT;

   typedef logic signed [DATA_W-1:0] fix_type;

   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      CSR_BOX_MIN_X = 3'd0,
      CSR_BOX_MIN_Y = 3'd1,
      CSR_BOX_MIN_Z = 3'd2,
      CSR_BOX_MAX_X = 3'd3,
      CSR_BOX_MAX_Y = 3'd4,
      CSR_BOX_MAX_Z = 3'd5
   } csr_index_type;

   // What one lane found for its axis.
   typedef struct packed {
      fix_type near_t;
      fix_type far_t;
      logic    ok;
   } slab_type;

   // Ray fields carried alongside the lanes.
   typedef struct packed {
      fix_type origin_x;
      fix_type origin_y;
      fix_type origin_z;
      fix_type direction_x;
      fix_type direction_y;
      fix_type direction_z;
      fix_type limit;
   } ray_type;

endpackage

FILE: hw/rtl/rbsi_div_pipe.sv
// ---------------------------------------------------------------------------
// Pipelined slab divider
// Signed (num * 2^FRAC_BITS) / den, truncated toward zero and saturated to
// 32 bits, one quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_div_pipe #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                enable,
   input  logic signed [rbsi_pkg::DIFF_W-1:0]  num,
   input  rbsi_pkg::fix_type                   den,
   output rbsi_pkg::fix_type                   quot
);

   localparam int unsigned QW   = rbsi_pkg::QUO_W;
   localparam int unsigned NW   = rbsi_pkg::DIFF_W + FRAC_BITS;
   localparam int unsigned HI_W = NW - QW;

   logic [rbsi_pkg::DIFF_W-1:0] nmag_ff;
   logic [QW-1:0]               dmag_ff;
   logic                        neg_ff;

   logic [NW-1:0]   nscaled;
   logic [HI_W-1:0] nhigh;

   logic [QW-1:0] rem_ff  [QW+1];
   logic [QW-1:0] low_ff  [QW+1];
   logic [QW-1:0] quo_ff  [QW+1];
   logic [QW-1:0] dm_ff   [QW+1];
   logic          ovf_ff  [QW+1];
   logic          sgn_ff  [QW+1];

   rbsi_pkg::fix_type quot_ff;
   rbsi_pkg::fix_type quot_in;
   logic              big;

   always_ff @(posedge clock) begin
      if (enable) begin
         nmag_ff <= num[rbsi_pkg::DIFF_W-1] ? (~num + 1'b1) : num;
         dmag_ff <= den[QW-1] ? (~den + 1'b1) : den;
         neg_ff  <= num[rbsi_pkg::DIFF_W-1] ^ den[QW-1];
      end
   end

   assign nscaled = {nmag_ff, {FRAC_BITS{1'b0}}};
   assign nhigh   = nscaled[NW-1:QW];

   // The quotient overflows 32 bits when the high part already reaches den.
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= QW'(nhigh);
         low_ff[0] <= nscaled[QW-1:0];
         quo_ff[0] <= '0;
         dm_ff[0]  <= dmag_ff;
         ovf_ff[0] <= QW'(nhigh) >= dmag_ff;
         sgn_ff[0] <= neg_ff;
      end
   end

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [QW:0] trial;
      logic [QW:0] diff;
      logic        ge;
      logic [QW-1:0] rem_in;

      always_comb begin
         trial  = {rem_ff[k], low_ff[k][QW-1]};
         diff   = trial - {1'b0, dm_ff[k]};
         ge     = trial >= {1'b0, dm_ff[k]};
         rem_in = ge ? diff[QW-1:0] : trial[QW-1:0];
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= {low_ff[k][QW-2:0], 1'b0};
            quo_ff[k+1] <= {quo_ff[k][QW-2:0], ge};
            dm_ff[k+1]  <= dm_ff[k];
            ovf_ff[k+1] <= ovf_ff[k];
            sgn_ff[k+1] <= sgn_ff[k];
         end
      end
   end

   always_comb begin
      big = ovf_ff[QW] || quo_ff[QW][QW-1];
      if (sgn_ff[QW]) begin
         quot_in = big ? rbsi_pkg::FIX_MIN : rbsi_pkg::fix_type'(~quo_ff[QW] + 1'b1);
      end else begin
         quot_in = big ? rbsi_pkg::FIX_MAX : rbsi_pkg::fix_type'(quo_ff[QW]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         quot_ff <= quot_in;
      end
   end

   assign quot = quot_ff;

endmodule

FILE: hw/rtl/rbsi_slab_lane.sv
// ---------------------------------------------------------------------------
// Slab lane
// One axis: both plane distances, ordered into near and far, with the
// zero-direction case handled by the inside test.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_slab_lane #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  rbsi_pkg::fix_type  box_lo,
   input  rbsi_pkg::fix_type  box_hi,
   input  rbsi_pkg::fix_type  origin,
   input  rbsi_pkg::fix_type  direction,
   output rbsi_pkg::slab_type slab
);

   localparam int unsigned DW = rbsi_pkg::DIFF_W;

   logic signed [DW-1:0] diff_lo_ff;
   logic signed [DW-1:0] diff_hi_ff;
   rbsi_pkg::fix_type    dir_ff;
   logic [1:0]           flag_ff [rbsi_pkg::DIV_LAT+1];

   rbsi_pkg::fix_type  t_lo;
   rbsi_pkg::fix_type  t_hi;
   rbsi_pkg::slab_type slab_ff;
   rbsi_pkg::slab_type slab_in;

   // flag bit 1: direction is zero, bit 0: origin lies inside the slab.
   always_ff @(posedge clock) begin
      if (enable) begin
         diff_lo_ff <= DW'(box_lo) - DW'(origin);
         diff_hi_ff <= DW'(box_hi) - DW'(origin);
         dir_ff     <= direction;
         flag_ff[0] <= {direction == '0, (origin >= box_lo) && (origin <= box_hi)};
      end
   end

   for (genvar s = 0; s < rbsi_pkg::DIV_LAT; s++) begin : g_flag
      always_ff @(posedge clock) begin
         if (enable) begin
            flag_ff[s+1] <= flag_ff[s];
         end
      end
   end

   rbsi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock  (clock),
      .enable (enable),
      .num    (diff_lo_ff),
      .den    (dir_ff),
      .quot   (t_lo)
   );

   rbsi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock  (clock),
      .enable (enable),
      .num    (diff_hi_ff),
      .den    (dir_ff),
      .quot   (t_hi)
   );

   always_comb begin
      if (flag_ff[rbsi_pkg::DIV_LAT][1]) begin
         slab_in.near_t = rbsi_pkg::FIX_MIN;
         slab_in.far_t  = rbsi_pkg::FIX_MAX;
         slab_in.ok     = flag_ff[rbsi_pkg::DIV_LAT][0];
      end else begin
         slab_in.near_t = (t_lo < t_hi) ? t_lo : t_hi;
         slab_in.far_t  = (t_lo < t_hi) ? t_hi : t_lo;
         slab_in.ok     = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         slab_ff <= slab_in;
      end
   end

   assign slab = slab_ff;

endmodule

FILE: hw/rtl/rbsi_merge.sv
// ---------------------------------------------------------------------------
// Slab merge
// Combines the three lanes into entry, exit and the hit decision, then
// forms the hit point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rbsi_merge #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               enable,
   input  rbsi_pkg::slab_type slab      [rbsi_pkg::NUM_AXES],
   input  rbsi_pkg::fix_type  origin    [rbsi_pkg::NUM_AXES],
   input  rbsi_pkg::fix_type  direction [rbsi_pkg::NUM_AXES],
   input  rbsi_pkg::fix_type  limit,
   output logic               hit,
   output rbsi_pkg::fix_type  entry_distance,
   output rbsi_pkg::fix_type  exit_distance,
   output rbsi_pkg::fix_type  point     [rbsi_pkg::NUM_AXES]
);

   localparam int unsigned NA    = rbsi_pkg::NUM_AXES;
   localparam int unsigned PW    = 2 * rbsi_pkg::DATA_W;
   localparam int unsigned SUM_W = PW + 1;

   rbsi_pkg::fix_type entry_in;
   rbsi_pkg::fix_type exit_in;

   rbsi_pkg::fix_type entry_ff;
   rbsi_pkg::fix_type exit_ff;
   logic              ok_ff;
   rbsi_pkg::fix_type limit_ff;
   rbsi_pkg::fix_type org0_ff [NA];
   rbsi_pkg::fix_type dir0_ff [NA];

   logic              hit1_ff;
   rbsi_pkg::fix_type entry1_ff;
   rbsi_pkg::fix_type exit1_ff;
   rbsi_pkg::fix_type org1_ff [NA];
   logic signed [PW-1:0] prod_ff [NA];

   logic              hit_ff;
   rbsi_pkg::fix_type entry2_ff;
   rbsi_pkg::fix_type exit2_ff;
   rbsi_pkg::fix_type point_ff [NA];

   always_comb begin
      entry_in = slab[0].near_t;
      exit_in  = slab[0].far_t;
      for (int a = 1; a < NA; a++) begin
         if (slab[a].near_t > entry_in) begin
            entry_in = slab[a].near_t;
         end
         if (slab[a].far_t < exit_in) begin
            exit_in = slab[a].far_t;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         entry_ff <= entry_in;
         exit_ff  <= exit_in;
         ok_ff    <= slab[0].ok && slab[1].ok && slab[2].ok;
         limit_ff <= limit;
         for (int a = 0; a < NA; a++) begin
            org0_ff[a] <= origin[a];
            dir0_ff[a] <= direction[a];
         end
      end
   end

   // A limit at the maximum value disables the limit test.
   always_ff @(posedge clock) begin
      if (enable) begin
         hit1_ff   <= ok_ff && (entry_ff <= exit_ff) &&
                      ((entry_ff < limit_ff) || (limit_ff == rbsi_pkg::FIX_MAX));
         entry1_ff <= entry_ff;
         exit1_ff  <= exit_ff;
         for (int a = 0; a < NA; a++) begin
            org1_ff[a] <= org0_ff[a];
            prod_ff[a] <= PW'(entry_ff) * PW'(dir0_ff[a]);
         end
      end
   end

   for (genvar a = 0; a < NA; a++) begin : g_point
      logic signed [SUM_W-1:0] sum;
      rbsi_pkg::fix_type       point_in;

      // Arithmetic shift rounds toward minus infinity.
      always_comb begin
         sum = SUM_W'(prod_ff[a] >>> FRAC_BITS) + SUM_W'(org1_ff[a]);
         if (sum > SUM_W'(rbsi_pkg::FIX_MAX)) begin
            point_in = rbsi_pkg::FIX_MAX;
         end else if (sum < SUM_W'(rbsi_pkg::FIX_MIN)) begin
            point_in = rbsi_pkg::FIX_MIN;
         end else begin
            point_in = sum[rbsi_pkg::DATA_W-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            point_ff[a] <= hit1_ff ? point_in : '0;
         end
      end

      assign point[a] = point_ff[a];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff    <= hit1_ff;
         entry2_ff <= hit1_ff ? entry1_ff : '0;
         exit2_ff  <= hit1_ff ? exit1_ff : '0;
      end
   end

   assign hit            = hit_ff;
   assign entry_distance = entry2_ff;
   assign exit_distance  = exit2_ff;

endmodule

FILE: hw/rtl/ray_box_slab_intersect_top.sv
// Throughput: one ray per cycle while the response side is not stalled; the
// 32-stage quotient pipelines in each axis lane set the depth, and every
// stage takes a new ray each cycle that the pipeline advances.
// The whole pipeline holds only while a response beat waits on rsp_ready.
// Reset (synchronous, active high) empties the pipeline and sets the box to
// the unit cube from the origin to 1.0 on every axis.
// ---------------------------------------------------------------------------
// Ray/box slab intersect top level
// Tests one ray per beat against the configured axis-aligned box.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_top_assert.svh"

module ray_box_slab_intersect_top #(
   parameter int unsigned FRAC_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,

   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_write_data,

   input  logic              req_valid,
   output logic              req_ready,
   input  rbsi_pkg::fix_type req_origin_x,
   input  rbsi_pkg::fix_type req_origin_y,
   input  rbsi_pkg::fix_type req_origin_z,
   input  rbsi_pkg::fix_type req_direction_x,
   input  rbsi_pkg::fix_type req_direction_y,
   input  rbsi_pkg::fix_type req_direction_z,
   input  rbsi_pkg::fix_type req_distance_limit,

   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_hit,
   output rbsi_pkg::fix_type rsp_entry_distance,
   output rbsi_pkg::fix_type rsp_exit_distance,
   output rbsi_pkg::fix_type rsp_hit_x,
   output rbsi_pkg::fix_type rsp_hit_y,
   output rbsi_pkg::fix_type rsp_hit_z
);

   localparam int unsigned NA  = rbsi_pkg::NUM_AXES;
   localparam int unsigned LAT = rbsi_pkg::TOTAL_LAT;

   // Box corners, one register per axis and corner.
   rbsi_pkg::fix_type box_lo_ff [NA];
   rbsi_pkg::fix_type box_hi_ff [NA];

   // The pipeline advances as a whole unless the response beat is stalled.
   logic             advance;
   logic [LAT-1:0]   valid_ff;

   rbsi_pkg::ray_type ray_in;
   rbsi_pkg::ray_type ray_ff [rbsi_pkg::LANE_LAT];

   rbsi_pkg::fix_type req_origin    [NA];
   rbsi_pkg::fix_type req_direction [NA];
   rbsi_pkg::slab_type slab         [NA];
   rbsi_pkg::fix_type mrg_origin    [NA];
   rbsi_pkg::fix_type mrg_direction [NA];
   rbsi_pkg::fix_type point         [NA];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NA; a++) begin
            box_lo_ff[a] <= '0;
            box_hi_ff[a] <= rbsi_pkg::fix_type'(1 << FRAC_BITS);
         end
      end else if (csr_write_enable) begin
         case (rbsi_pkg::csr_index_type'(csr_index))
            rbsi_pkg::CSR_BOX_MIN_X: begin
               box_lo_ff[0] <= csr_write_data;
            end
            rbsi_pkg::CSR_BOX_MIN_Y: begin
               box_lo_ff[1] <= csr_write_data;
            end
            rbsi_pkg::CSR_BOX_MIN_Z: begin
               box_lo_ff[2] <= csr_write_data;
            end
            rbsi_pkg::CSR_BOX_MAX_X: begin
               box_hi_ff[0] <= csr_write_data;
            end
            rbsi_pkg::CSR_BOX_MAX_Y: begin
               box_hi_ff[1] <= csr_write_data;
            end
            rbsi_pkg::CSR_BOX_MAX_Z: begin
               box_hi_ff[2] <= csr_write_data;
            end
            default: begin
            end
         endcase
      end
   end

   // The output stage is the last pipeline register, so a new request beat
   // is taken whenever the response beat is either absent or leaving.
   assign advance   = !valid_ff[LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = valid_ff[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[LAT-2:0], req_valid};
      end
   end

   // The ray itself rides along beside the lanes until the merge stage.
   always_comb begin
      ray_in.origin_x    = req_origin_x;
      ray_in.origin_y    = req_origin_y;
      ray_in.origin_z    = req_origin_z;
      ray_in.direction_x = req_direction_x;
      ray_in.direction_y = req_direction_y;
      ray_in.direction_z = req_direction_z;
      ray_in.limit       = req_distance_limit;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ray_ff[0] <= ray_in;
         for (int s = 1; s < rbsi_pkg::LANE_LAT; s++) begin
            ray_ff[s] <= ray_ff[s-1];
         end
      end
   end

   assign req_origin[0]    = req_origin_x;
   assign req_origin[1]    = req_origin_y;
   assign req_origin[2]    = req_origin_z;
   assign req_direction[0] = req_direction_x;
   assign req_direction[1] = req_direction_y;
   assign req_direction[2] = req_direction_z;

   // One lane per axis, all three working on the same ray.
   for (genvar a = 0; a < NA; a++) begin : g_lane
      rbsi_slab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock     (clock),
         .enable    (advance),
         .box_lo    (box_lo_ff[a]),
         .box_hi    (box_hi_ff[a]),
         .origin    (req_origin[a]),
         .direction (req_direction[a]),
         .slab      (slab[a])
      );
   end

   assign mrg_origin[0]    = ray_ff[rbsi_pkg::LANE_LAT-1].origin_x;
   assign mrg_origin[1]    = ray_ff[rbsi_pkg::LANE_LAT-1].origin_y;
   assign mrg_origin[2]    = ray_ff[rbsi_pkg::LANE_LAT-1].origin_z;
   assign mrg_direction[0] = ray_ff[rbsi_pkg::LANE_LAT-1].direction_x;
   assign mrg_direction[1] = ray_ff[rbsi_pkg::LANE_LAT-1].direction_y;
   assign mrg_direction[2] = ray_ff[rbsi_pkg::LANE_LAT-1].direction_z;

   // The merge stage's final registers are the response payload.
   rbsi_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
      .clock          (clock),
      .enable         (advance),
      .slab           (slab),
      .origin         (mrg_origin),
      .direction      (mrg_direction),
      .limit          (ray_ff[rbsi_pkg::LANE_LAT-1].limit),
      .hit            (rsp_hit),
      .entry_distance (rsp_entry_distance),
      .exit_distance  (rsp_exit_distance),
      .point          (point)
   );

   assign rsp_hit_x = point[0];
   assign rsp_hit_y = point[1];
   assign rsp_hit_z = point[2];

   // A miss carries all-zero distances and hit point.
   `RBSI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_valid && !rsp_hit, (rsp_entry_distance == '0) && (rsp_exit_distance == '0) && (rsp_hit_x == '0) && (rsp_hit_y == '0) && (rsp_hit_z == '0), "miss response carries nonzero fields")
   // A hit always has entry at or before exit.
   `RBSI_ASSERT_IMPL(a_hit_order, clock, reset, rsp_valid && rsp_hit, rsp_entry_distance <= rsp_exit_distance, "hit with entry beyond exit")
   // The request side only stalls behind a stalled response beat.
   `RBSI_ASSERT_IMPL(a_stall_cause, clock, reset, !req_ready, rsp_valid && !rsp_ready, "request stalled without a response stall")
   // An accepted beat occupies the first pipeline stage.
   `RBSI_ASSERT_NEXT(a_accept_enters, clock, reset, req_valid && req_ready, valid_ff[0], "accepted beat lost at pipeline entry")

endmodule
